// ===== hdl/fedl_pkg.sv =====
// Shared types and constants of the feedback echo delay unit.
// No dependencies; imported by fedl_ctrl, fedl_dp and the top level in hdl/.
package fedl_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int GAIN_W    = 15;
	localparam int POS_W     = 15;
	localparam int CFG_IDX_W = 3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MODE       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DRY_GAIN   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WET_GAIN   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FB_GAIN    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_LAST_INDEX = 3'd4;

	// register reset values
	localparam logic              MODE_RST       = 1'b1;
	localparam logic [GAIN_W-1:0] DRY_GAIN_RST   = 15'd13107;
	localparam logic [GAIN_W-1:0] WET_GAIN_RST   = 15'd19661;
	localparam logic [GAIN_W-1:0] FB_GAIN_RST    = 15'd13107;
	localparam logic [POS_W-1:0]  LAST_INDEX_RST = 15'd25600;

	typedef enum logic {
		ST_IDLE,
		ST_CALC
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;    // sample taken, ring read issued
		logic finish;  // result formed, ring written back, output loaded
	} cmd_t;

	typedef struct packed {
		logic              mode;
		logic [GAIN_W-1:0] dry_gain;
		logic [GAIN_W-1:0] wet_gain;
		logic [GAIN_W-1:0] feedback_gain;
		logic [POS_W-1:0]  delay_last_index;
	} cfg_t;

endpackage

// ===== hdl/fedl_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module fedl_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32768
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== hdl/fedl_ctrl.sv =====
// Controller of the feedback echo delay unit: sequencing and output handshake.
// Depends on fedl_pkg.
module fedl_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	output fedl_pkg::cmd_t cmd
);

	import fedl_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd.load   = 1'b0;
		cmd.finish = 1'b0;
		in_stall   = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CALC;
				end
			end
			ST_CALC: begin
				// hold until the output register can take the result
				if (slot_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

	a_rise_from_calc: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_CALC))
		else $error("result raised without a calculation");

	a_calc_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CALC && out_valid_q && out_stall) |=> state_q == ST_CALC)
		else $error("calculation left while output slot busy");

	a_load_after_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == ST_CALC)
		else $error("load did not start a calculation");

endmodule

// ===== hdl/fedl_dp.sv =====
// Datapath of the feedback echo delay unit: ring memory, pointers, Q arithmetic.
// Depends on fedl_pkg and fedl_ram.
module fedl_dp #(
	parameter int RING_DEPTH     = 32768,
	parameter int GAIN_FRAC_BITS = 15
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  fedl_pkg::cmd_t                        cmd,
	input  fedl_pkg::cfg_t                        cfg,
	input  logic signed [fedl_pkg::SAMPLE_W-1:0]  sample_in,
	output logic signed [fedl_pkg::SAMPLE_W-1:0]  sample_out
);

	import fedl_pkg::*;

	localparam int AW    = $clog2(RING_DEPTH);
	localparam int PXW   = SAMPLE_W + GAIN_W + 2;      // x * (dry + wet)
	localparam int WFW   = 2 * GAIN_W;                 // wet * fb
	localparam int WSW   = WFW + 1 + SAMPLE_W;         // wet * fb * s
	localparam int TW0   = (PXW + GAIN_FRAC_BITS > WSW) ? PXW + GAIN_FRAC_BITS : WSW;
	localparam int TW    = TW0 + 1;
	localparam int SH    = 2 * GAIN_FRAC_BITS;
	localparam int QW    = (TW - SH > SAMPLE_W + 1) ? TW - SH : SAMPLE_W + 1;
	localparam logic signed [QW-1:0] Q_MAX = QW'(32767);
	localparam logic signed [QW-1:0] Q_MIN = -(QW'(32768));

	// pointers
	logic [POS_W-1:0] write_pos_q;
	logic [AW-1:0]    addr_q;
	logic [AW:0]      fill_q;

	// first stage
	logic signed [SAMPLE_W-1:0] x_s1;
	logic signed [PXW-1:0]      px_s1;
	logic                       mode_s1;
	logic                       hit_s1;

	logic [WFW-1:0]             wf_q;
	logic signed [SAMPLE_W-1:0] out_q;

	logic [GAIN_W:0]            gsum;
	logic signed [GAIN_W+1:0]   gsum_s;
	logic signed [PXW-1:0]      px;
	logic [SAMPLE_W-1:0]        rd_data;
	logic signed [SAMPLE_W-1:0] stored;
	logic signed [WSW-1:0]      ws;
	logic signed [TW-1:0]       px_ext, ws_ext, t, t_sh;
	logic signed [QW-1:0]       q;
	logic                       rnd;
	logic signed [SAMPLE_W-1:0] y_sat, y;

	// (x*2^F + fb*s)*wet + dry*x*2^F == x*(dry+wet)*2^F + (wet*fb)*s
	assign gsum   = {1'b0, cfg.dry_gain} + {1'b0, cfg.wet_gain};
	assign gsum_s = $signed({1'b0, gsum});
	assign px     = sample_in * gsum_s;

	assign stored = hit_s1 ? $signed(rd_data) : '0;   // never-written entries read zero
	assign ws     = $signed({1'b0, wf_q}) * stored;

	assign px_ext = TW'(px_s1);
	assign ws_ext = TW'(ws);
	assign t      = (px_ext <<< GAIN_FRAC_BITS) + ws_ext;
	assign t_sh   = t >>> SH;
	// shift floors; bump negatives with a fraction to truncate toward zero
	assign rnd    = t[TW-1] && (|t[SH-1:0]);
	assign q      = $signed(t_sh[QW-1:0] + {{(QW-1){1'b0}}, rnd});

	always_comb begin
		if (q > Q_MAX) begin
			y_sat = 16'sh7fff;
		end else if (q < Q_MIN) begin
			y_sat = 16'sh8000;
		end else begin
			y_sat = q[SAMPLE_W-1:0];
		end
	end

	assign y = mode_s1 ? y_sat : x_s1;

	fedl_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (RING_DEPTH)
	) u_ring (
		.clk     (clk),
		.wr_en   (cmd.finish && mode_s1),
		.wr_addr (addr_q),
		.wr_data (y),
		.rd_en   (cmd.load && cfg.mode),
		.rd_addr (addr_q),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk) begin
		wf_q <= cfg.wet_gain * cfg.feedback_gain;
		if (cmd.load) begin
			x_s1    <= sample_in;
			px_s1   <= px;
			mode_s1 <= cfg.mode;
			hit_s1  <= ({1'b0, addr_q} < fill_q);
		end
		if (cmd.finish) begin
			out_q <= y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_pos_q <= '0;
			addr_q      <= '0;
			fill_q      <= '0;
		end else if (cmd.finish && mode_s1) begin
			if ({1'b0, addr_q} == fill_q) begin
				fill_q <= fill_q + (AW+1)'(1);
			end
			if (write_pos_q < cfg.delay_last_index) begin
				write_pos_q <= write_pos_q + POS_W'(1);
				addr_q      <= (addr_q == AW'(RING_DEPTH - 1)) ? '0 : addr_q + AW'(1);
			end else begin
				write_pos_q <= '0;
				addr_q      <= '0;
			end
		end
	end

	assign sample_out = out_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= (AW+1)'(RING_DEPTH))
		else $error("fill count beyond ring depth");

	a_addr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		addr_q <= AW'(RING_DEPTH - 1))
		else $error("ring address beyond depth");

	a_addr_tracks_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(write_pos_q == '0) |-> (addr_q == '0))
		else $error("ring address out of step with write position");

endmodule

// ===== hdl/feedback_echo_delay_unit.sv =====
// Top level of the feedback echo delay unit: configuration registers and wiring.
// Depends on fedl_pkg, fedl_ctrl, fedl_dp (and fedl_ram below it).
//
//  channel     | handshake                          | payload
//  ------------+------------------------------------+--------------------------
//  sample in   | sample_in_valid / sample_in_stall  | sample_in  (s16)
//  sample out  | sample_out_valid / sample_out_stall| sample_out (s16)
//  config      | cfg_wr_en (no wait)                | cfg_index (3b), cfg_data (15b)
//
// Per sample, the transfer edge issues the ring read and forms x*(dry+wet);
// the second step forms the result, writes it back to the ring and loads the
// output register. The ring memory's single read-then-write per sample sets
// this split. No new sample is taken until the second step is done, though
// one is taken while a result waits on the output. A stalled output holds the
// second step until the register frees. Reset is immediate: the ring needs no
// clearing pass, since a fill count marks unwritten entries, which read as zero.
module feedback_echo_delay_unit #(
	parameter int RING_DEPTH     = 32768,
	parameter int GAIN_FRAC_BITS = 15
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  sample_in_valid,
	output logic                                  sample_in_stall,
	input  logic signed [fedl_pkg::SAMPLE_W-1:0]  sample_in,
	output logic                                  sample_out_valid,
	input  logic                                  sample_out_stall,
	output logic signed [fedl_pkg::SAMPLE_W-1:0]  sample_out,
	input  logic                                  cfg_wr_en,
	input  logic [fedl_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [fedl_pkg::GAIN_W-1:0]           cfg_data
);

	import fedl_pkg::*;

	cfg_t cfg_q;
	cmd_t cmd;

	// register file; writes to unused indexes fall through
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode             <= MODE_RST;
			cfg_q.dry_gain         <= DRY_GAIN_RST;
			cfg_q.wet_gain         <= WET_GAIN_RST;
			cfg_q.feedback_gain    <= FB_GAIN_RST;
			cfg_q.delay_last_index <= LAST_INDEX_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_MODE:       cfg_q.mode             <= cfg_data[0];
				CFG_DRY_GAIN:   cfg_q.dry_gain         <= cfg_data;
				CFG_WET_GAIN:   cfg_q.wet_gain         <= cfg_data;
				CFG_FB_GAIN:    cfg_q.feedback_gain    <= cfg_data;
				CFG_LAST_INDEX: cfg_q.delay_last_index <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	fedl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample_in_valid),
		.in_stall  (sample_in_stall),
		.out_valid (sample_out_valid),
		.out_stall (sample_out_stall),
		.cmd       (cmd)
	);

	fedl_dp #(
		.RING_DEPTH     (RING_DEPTH),
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.cfg        (cfg_q),
		.sample_in  (sample_in),
		.sample_out (sample_out)
	);

endmodule

// ===== dv/tb_feedback_echo_delay_unit.sv =====
// Self-checking testbench for feedback_echo_delay_unit: directed and random samples
// under random sender bursts and receiver stalls. Results are checked against a
// cycle-free echo predictor. Depends on fedl_pkg and the RTL under hdl/.
module tb_feedback_echo_delay_unit;
	import fedl_pkg::*;

	localparam int     RING_DEPTH   = 32768;
	localparam int     GAIN_FRAC    = 15;
	localparam longint GAIN_ONE     = longint'(1) << GAIN_FRAC;
	localparam int     RANDOM_ITEMS = 1900;
	// room for ~2000 samples under gaps and stalls, plus drains, several times over
	localparam int     CYCLE_LIMIT  = 400000;

	typedef enum {
		STALL_NONE,
		STALL_HALF,
		STALL_LIGHT,
		STALL_SOLID
	} stall_kind_t;

	logic                              clk              = 1'b0;
	logic                              arst_n           = 1'b0;
	logic                              sample_in_valid  = 1'b0;
	logic                              sample_in_stall;
	logic signed [SAMPLE_W-1:0]        sample_in        = '0;
	logic                              sample_out_valid;
	logic                              sample_out_stall = 1'b0;
	logic signed [SAMPLE_W-1:0]        sample_out;
	logic                              cfg_wr_en        = 1'b0;
	logic [CFG_IDX_W-1:0]              cfg_index        = '0;
	logic [GAIN_W-1:0]                 cfg_data         = '0;

	// predictor state: its own copy of the registers, ring and write position
	logic                              sh_mode;
	logic [GAIN_W-1:0]                 sh_dry;
	logic [GAIN_W-1:0]                 sh_wet;
	logic [GAIN_W-1:0]                 sh_fb;
	logic [POS_W-1:0]                  sh_last;
	logic signed [SAMPLE_W-1:0]        ring_copy [RING_DEPTH];
	logic [POS_W-1:0]                  pos_copy;

	// output samples still owed by the block, oldest first
	logic signed [SAMPLE_W-1:0]        samples_due [$];
	logic signed [SAMPLE_W-1:0]        due_sample;

	int unsigned                       fail_count  = 0;
	int unsigned                       cycle_count = 0;
	int unsigned                       burst_left  = 0;
	int unsigned                       stall_left  = 0;
	stall_kind_t                       stall_kind  = STALL_NONE;
	// intended levels of valid and write enable, so each gets one update per step
	bit                                valid_high  = 1'b0;
	bit                                wr_high     = 1'b0;

	feedback_echo_delay_unit #(
		.RING_DEPTH     (RING_DEPTH),
		.GAIN_FRAC_BITS (GAIN_FRAC)
	) u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.sample_in_valid  (sample_in_valid),
		.sample_in_stall  (sample_in_stall),
		.sample_in        (sample_in),
		.sample_out_valid (sample_out_valid),
		.sample_out_stall (sample_out_stall),
		.sample_out       (sample_out),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	// watchdog: a hung handshake ends the run here
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("tb_feedback_echo_delay_unit: FAIL");
		$finish;
	end

	// One echo step: wet*(x + fb*stored) + dry*x at scale 2^2F, truncated toward
	// zero and clamped. The clamped value goes back into the ring slot.
	// Bypass leaves ring and position alone.
	function automatic logic signed [SAMPLE_W-1:0] echo_sample(
		input logic signed [SAMPLE_W-1:0] x
	);
		longint xs;
		longint stored;
		longint mix;
		longint acc;
		longint q;
		int     slot;
		if (!sh_mode)
			return x;
		slot   = int'(pos_copy) % RING_DEPTH;
		xs     = longint'(x);
		stored = longint'(ring_copy[slot]);
		mix    = xs * GAIN_ONE + longint'(sh_fb) * stored;
		acc    = longint'(sh_dry) * xs * GAIN_ONE + longint'(sh_wet) * mix;
		q      = acc / (GAIN_ONE * GAIN_ONE);   // SV division truncates toward zero
		if (q > 32767)
			q = 32767;
		else if (q < -32768)
			q = -32768;
		ring_copy[slot] = q[SAMPLE_W-1:0];
		// a position past the last index (after a shrink) also wraps to zero
		pos_copy = (pos_copy < sh_last) ? pos_copy + POS_W'(1) : '0;
		return q[SAMPLE_W-1:0];
	endfunction

	// Register write; only called with nothing in flight.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		wr_high = 1'b1;
		@(posedge clk);
		case (idx)
			CFG_MODE:       sh_mode = data[0];
			CFG_DRY_GAIN:   sh_dry  = data;
			CFG_WET_GAIN:   sh_wet  = data;
			CFG_FB_GAIN:    sh_fb   = data;
			CFG_LAST_INDEX: sh_last = data;
			default: ;      // unmapped index: no effect
		endcase
	endtask

	// One input transfer. The sender runs in bursts; a gap drops valid between them.
	task automatic send_sample(input logic signed [SAMPLE_W-1:0] x);
		int unsigned gap;
		if (wr_high) begin
			cfg_wr_en <= 1'b0;
			wr_high = 1'b0;
		end
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
				: $urandom_range(1, 12);
			if (gap != 0) begin
				if (valid_high) begin
					sample_in_valid <= 1'b0;
					valid_high = 1'b0;
				end
				repeat (gap) @(posedge clk);
			end
		end
		sample_in_valid <= 1'b1;
		sample_in       <= x;
		valid_high = 1'b1;
		@(posedge clk);
		while (sample_in_stall)
			@(posedge clk);
		// transfer took place at this edge
		samples_due.push_back(echo_sample(x));
		burst_left--;
	endtask

	// Idle the input and wait for every owed sample to come out.
	task automatic drain_outputs();
		if (valid_high) begin
			sample_in_valid <= 1'b0;
			valid_high = 1'b0;
		end
		while (samples_due.size() != 0)
			@(posedge clk);
	endtask

	// Receiver: stalls in runs, each run picks its own flavour and length.
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_kind = stall_kind_t'($urandom_range(0, 3));
			stall_left = (stall_kind == STALL_SOLID) ? $urandom_range(1, 8)
				: $urandom_range(1, 40);
		end else begin
			stall_left--;
		end
		case (stall_kind)
			STALL_NONE:  sample_out_stall <= 1'b0;
			STALL_HALF:  sample_out_stall <= ($urandom_range(0, 1) == 0);
			STALL_LIGHT: sample_out_stall <= ($urandom_range(0, 3) == 0);
			default:     sample_out_stall <= 1'b1;
		endcase
	end

	// Output checker: each transfer against the oldest owed sample.
	always @(posedge clk) begin
		if (arst_n && sample_out_valid && !sample_out_stall) begin
			if (samples_due.size() == 0) begin
				$error("sample_out: unexpected transfer, got %0d", sample_out);
				fail_count++;
			end else begin
				due_sample = samples_due.pop_front();
				if (sample_out !== due_sample) begin
					$error("sample_out: expected %0d, got %0d", due_sample, sample_out);
					fail_count++;
				end
			end
		end
	end

	function automatic logic signed [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(0, 7))
			0:       return 16'sh7FFF;
			1:       return 16'sh8000;
			2:       return SAMPLE_W'($urandom_range(0, 4) - 2);   // around zero
			3:       return SAMPLE_W'($urandom_range(0, 255) - 128);
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	function automatic logic [GAIN_W-1:0] pick_gain();
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return '1;
			default: return GAIN_W'($urandom);
		endcase
	endfunction

	// Mostly short rings so the echo comes round within a phase; now and then a long one.
	function automatic logic [POS_W-1:0] pick_last_index();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return POS_W'($urandom_range(0, 7));
			4, 5, 6:    return POS_W'($urandom_range(8, 127));
			7, 8:       return POS_W'($urandom);
			default:    return '1;
		endcase
	endfunction

	// Reset values, ring starts empty (reads as zero).
	task automatic test_reset_defaults();
		send_sample(16'sh7FFF);
		send_sample(16'sh8000);
		send_sample(-16'sd1);
	endtask

	// Bypass: upper data bits on the mode write are dropped; ring and position hold.
	task automatic test_bypass();
		drain_outputs();
		write_reg(CFG_MODE, 15'h7FFE);
		send_sample(16'sh7FFF);
		send_sample(16'sh8000);
		send_sample(16'sh1234);
		drain_outputs();
		write_reg(CFG_MODE, 15'h0001);
	endtask

	// Full-scale gains on a one-slot ring: clamps both ways. Position is past the
	// new last index here, so the first step also wraps.
	task automatic test_saturation();
		drain_outputs();
		write_reg(CFG_DRY_GAIN, '1);
		write_reg(CFG_WET_GAIN, '1);
		write_reg(CFG_FB_GAIN, '1);
		write_reg(CFG_LAST_INDEX, '0);
		send_sample(16'sh7FFF);
		send_sample(16'sh7FFF);
		send_sample(16'sh8000);
		send_sample(16'sh8000);
	endtask

	// Tiny products of negative sign must truncate toward zero, not floor.
	task automatic test_truncation();
		drain_outputs();
		write_reg(CFG_DRY_GAIN, 15'd1);
		write_reg(CFG_WET_GAIN, '0);
		write_reg(CFG_FB_GAIN, '0);
		write_reg(CFG_LAST_INDEX, 15'd1);
		send_sample(-16'sd1);
		send_sample(16'sd1);
		drain_outputs();
		write_reg(CFG_DRY_GAIN, '0);
		write_reg(CFG_WET_GAIN, 15'd1);
		send_sample(16'sh8000);
		send_sample(-16'sd1);
	endtask

	task automatic test_zero_gains();
		drain_outputs();
		write_reg(CFG_WET_GAIN, '0);
		send_sample(16'sh7FFF);
		send_sample(16'sh8000);
	endtask

	// Longest ring, then shrink the last index below the current position.
	task automatic test_last_index_shrink();
		drain_outputs();
		write_reg(CFG_DRY_GAIN, DRY_GAIN_RST);
		write_reg(CFG_WET_GAIN, WET_GAIN_RST);
		write_reg(CFG_FB_GAIN, '1);
		write_reg(CFG_LAST_INDEX, '1);
		repeat (6)
			send_sample(pick_sample());
		drain_outputs();
		write_reg(CFG_LAST_INDEX, 15'd2);
		send_sample(16'sh4000);
		send_sample(-16'sh4000);
	endtask

	// Writes to indexes past the register list must change nothing.
	task automatic test_unmapped_index();
		drain_outputs();
		for (int i = int'(CFG_LAST_INDEX) + 1; i < (1 << CFG_IDX_W); i++)
			write_reg(i[CFG_IDX_W-1:0], (i[0]) ? '1 : '0);
		send_sample(16'sh2AAA);
		send_sample(-16'sh2AAA);
	endtask

	// Phases of random settings, each followed by a run of samples.
	task automatic test_random_phases();
		int unsigned      sent;
		int unsigned      run_len;
		logic [GAIN_W-1:0] mode_word;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			drain_outputs();
			if ($urandom_range(0, 2) == 0) begin
				mode_word    = GAIN_W'($urandom);
				mode_word[0] = ($urandom_range(0, 4) != 0);   // echo most of the time
				write_reg(CFG_MODE, mode_word);
			end
			if ($urandom_range(0, 1) == 0)
				write_reg(CFG_DRY_GAIN, pick_gain());
			if ($urandom_range(0, 1) == 0)
				write_reg(CFG_WET_GAIN, pick_gain());
			if ($urandom_range(0, 1) == 0)
				write_reg(CFG_FB_GAIN, pick_gain());
			if ($urandom_range(0, 1) == 0)
				write_reg(CFG_LAST_INDEX, pick_last_index());
			if ($urandom_range(0, 9) == 0)
				write_reg(CFG_IDX_W'($urandom_range(int'(CFG_LAST_INDEX) + 1,
					(1 << CFG_IDX_W) - 1)), GAIN_W'($urandom));
			run_len = $urandom_range(10, 120);
			repeat (run_len)
				send_sample(pick_sample());
			sent += run_len;
		end
	endtask

	initial begin
		sh_mode  = MODE_RST;
		sh_dry   = DRY_GAIN_RST;
		sh_wet   = WET_GAIN_RST;
		sh_fb    = FB_GAIN_RST;
		sh_last  = LAST_INDEX_RST;
		pos_copy = '0;
		foreach (ring_copy[i])
			ring_copy[i] = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_bypass();
		test_saturation();
		test_truncation();
		test_zero_gains();
		test_last_index_shrink();
		test_unmapped_index();
		test_random_phases();

		drain_outputs();
		// spare cycles to catch stray output transfers
		repeat (16) @(posedge clk);
		if (fail_count == 0)
			$display("tb_feedback_echo_delay_unit: PASS");
		else
			$display("tb_feedback_echo_delay_unit: FAIL");
		$finish;
	end

endmodule

// ===== feedback_echo_delay_unit.f =====
hdl/fedl_pkg.sv
hdl/fedl_ram.sv
hdl/fedl_ctrl.sv
hdl/fedl_dp.sv
hdl/feedback_echo_delay_unit.sv
dv/tb_feedback_echo_delay_unit.sv
